// File: design/vdu_pkg.sv
// Shared types and constants for the vector distance unit.
`default_nettype none
package vdu_pkg;

  localparam logic [1:0] OP_DOT   = 2'd0;
  localparam logic [1:0] OP_DSQ   = 2'd1;
  localparam logic [1:0] OP_SPILL = 2'd2;
  // The fourth op code runs as the spill-penalized distance.
  localparam logic [1:0] OP_SPILL_ALT = 2'd3;

  localparam int ACC_W = 48;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam int LAM_W     = 16;
  localparam int NUM_W     = 2 * ACC_W + LAM_W;
  localparam int DEN_W     = ACC_W + 8;
  localparam int MUL_STEPS = ACC_W;
  localparam int DIV_STEPS = NUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] proj;
    logic                    sat;
    logic [1:0]              mode;
    logic [ACC_W-1:0]        rnorm;
  } job_t;

endpackage
`default_nettype wire

// File: design/vdu_front.sv
// Front end: element intake, product stage and saturating accumulators.
`default_nettype none
module vdu_front #(
  parameter int EW      = 16,
  parameter int MAX_DIM = 4096
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  output logic                         ready_o,
  input  wire logic [1:0]              op_i,
  input  wire logic signed [EW-1:0]    a_i,
  input  wire logic signed [EW-1:0]    b_i,
  input  wire logic signed [EW-1:0]    r_i,
  input  wire logic [vdu_pkg::ACC_W-1:0] rnorm_i,
  input  wire logic                    last_i,
  input  wire logic [vdu_pkg::Q_CW-1:0] q_count_i,
  output logic                         push_o,
  output vdu_pkg::job_t                job_o
);
  import vdu_pkg::*;

  localparam int PW = 2 * EW + 2;
  localparam int WW = (PW > 50 ? PW : 50) + 1;
  localparam int NW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic signed [WW-1:0] LIM_P  = WW'(1) << ACC_W;
  localparam logic signed [WW-1:0] LIM_N  = -LIM_P;
  localparam logic signed [WW-1:0] AMAX_W = {{(WW-ACC_W){1'b0}}, ACC_MAX};
  localparam logic signed [WW-1:0] AMIN_W = -AMAX_W - 1;

  // Saturating add of one product: {sat, value}.
  function automatic logic [ACC_W:0] mac(input logic signed [ACC_W-1:0] acc,
                                         input logic signed [PW-1:0] p);
    logic signed [WW-1:0] aw;
    logic signed [WW-1:0] pw;
    logic signed [WW-1:0] s;
    aw = {{(WW-ACC_W){acc[ACC_W-1]}}, acc};
    pw = {{(WW-PW){p[PW-1]}}, p};
    s  = aw + pw;
    if (pw >= LIM_P)       mac = {1'b1, ACC_MAX};
    else if (pw <= LIM_N)  mac = {1'b1, ACC_MIN};
    else if (s > AMAX_W)   mac = {1'b1, ACC_MAX};
    else if (s < AMIN_W)   mac = {1'b1, ACC_MIN};
    else                   mac = {1'b0, s[ACC_W-1:0]};
  endfunction

  logic              in_vec_q, in_vec_d;
  logic [1:0]        mode_q, mode_cur;
  logic [NW-1:0]     cnt_q, cnt_d;
  logic              accept, eff_last;
  logic signed [EW:0] a_x, b_x, r_x, diff, x_op, y_op;

  logic                    s1_valid_q, s1_first_q, s1_last_q;
  logic [1:0]              s1_mode_q;
  logic [ACC_W-1:0]        s1_rnorm_q;
  logic signed [PW-1:0]    s1_prod_q, s1_proj_q;

  logic signed [ACC_W-1:0] sum_q, proj_q, sum_d, proj_d, base_sum, base_proj;
  logic                    sat_q, sat_d, base_sat;
  logic [ACC_W:0]          r1, r2;
  logic [Q_CW:0]           credit_use;

  assign accept   = valid_i & ready_o;
  assign eff_last = last_i | (cnt_q == NW'(MAX_DIM - 1));

  always_comb begin
    if (in_vec_q)            mode_cur = mode_q;
    else if (op_i == OP_DOT) mode_cur = OP_DOT;
    else if (op_i == OP_DSQ) mode_cur = OP_DSQ;
    else                     mode_cur = OP_SPILL;
  end

  always_comb begin
    in_vec_d = 1'b1;
    cnt_d    = cnt_q + NW'(1);
    if (eff_last) begin
      in_vec_d = 1'b0;
      cnt_d    = '0;
    end
  end

  // Hold a slot for every last element still in flight.
  assign credit_use = {1'b0, q_count_i} + (Q_CW+1)'(s1_valid_q & s1_last_q);
  assign ready_o    = credit_use < (Q_CW+1)'(Q_DEPTH);

  assign a_x  = {a_i[EW-1], a_i};
  assign b_x  = {b_i[EW-1], b_i};
  assign r_x  = {r_i[EW-1], r_i};
  assign diff = a_x - b_x;
  assign x_op = (mode_cur == OP_DOT) ? a_x : diff;
  assign y_op = (mode_cur == OP_DOT) ? b_x : diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vec_q   <= 1'b0;
      mode_q     <= OP_DOT;
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        in_vec_q <= in_vec_d;
        mode_q   <= mode_cur;
        cnt_q    <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_first_q <= ~in_vec_q;
      s1_last_q  <= eff_last;
      s1_mode_q  <= mode_cur;
      s1_rnorm_q <= rnorm_i;
      s1_prod_q  <= PW'(x_op * y_op);
      s1_proj_q  <= PW'(r_x * diff);
    end
  end

  always_comb begin
    base_sum  = s1_first_q ? '0 : sum_q;
    base_proj = s1_first_q ? '0 : proj_q;
    base_sat  = s1_first_q ? 1'b0 : sat_q;
    r1        = mac(base_sum, s1_prod_q);
    r2        = mac(base_proj, s1_proj_q);
    sum_d     = r1[ACC_W-1:0];
    proj_d    = base_proj;
    sat_d     = base_sat | r1[ACC_W];
    if (s1_mode_q == OP_SPILL) begin
      proj_d = r2[ACC_W-1:0];
      sat_d  = sat_d | r2[ACC_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      proj_q <= '0;
      sat_q  <= 1'b0;
    end else if (s1_valid_q) begin
      sum_q  <= sum_d;
      proj_q <= proj_d;
      sat_q  <= sat_d;
    end
  end

  assign push_o      = s1_valid_q & s1_last_q;
  assign job_o.sum   = sum_d;
  assign job_o.proj  = proj_d;
  assign job_o.sat   = sat_d;
  assign job_o.mode  = s1_mode_q;
  assign job_o.rnorm = s1_rnorm_q;

endmodule
`default_nettype wire

// File: design/vdu_job_fifo.sv
// Short job queue between the accumulate front end and the finishing back end.
`default_nettype none
module vdu_job_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  vdu_pkg::job_t           data_i,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output vdu_pkg::job_t           data_o,
  output logic [vdu_pkg::Q_CW-1:0] count_o
);
  import vdu_pkg::*;

  job_t              mem_q [Q_DEPTH];
  logic [Q_AW-1:0]   wr_q, rd_q;
  logic [Q_CW-1:0]   cnt_q;

  function automatic logic [Q_AW-1:0] bump(input logic [Q_AW-1:0] p);
    bump = (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + Q_AW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= bump(wr_q);
      if (pop_i)  rd_q <= bump(rd_q);
      cnt_q <= cnt_q + Q_CW'(push_i) - Q_CW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule
`default_nettype wire

// File: design/vdu_back.sv
// Back end: spill penalty by shift-add multiply and restoring divide, result register.
`default_nettype none
module vdu_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       job_valid_i,
  input  vdu_pkg::job_t                   job_i,
  output logic                            pop_o,
  input  wire logic [vdu_pkg::LAM_W-1:0]  spill_weight_i,
  output logic                            m_tvalid_o,
  input  wire logic                       m_tready_i,
  output logic [vdu_pkg::ACC_W-1:0]       distance_o,
  output logic                            overflow_o
);
  import vdu_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ACC  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e            state_q;
  job_t              job_q;
  logic [NUM_W-1:0]  lp_q, num_q;
  logic [ACC_W-1:0]  pm_q, pmag, room, quo_q;
  logic [STEP_W-1:0] step_q;
  logic [DEN_W:0]    rem_q, rem_s, den;
  logic              big_q, ge, load_out;
  logic [ACC_W-1:0]  res_val;
  logic              res_ovf;
  logic [ACC_W-1:0]  dist_q;
  logic              ovf_q, valid_q;

  assign pmag  = job_q.proj[ACC_W-1] ? ACC_W'(-job_q.proj) : job_q.proj;
  assign den   = {1'b0, job_q.rnorm, 8'b0};
  assign rem_s = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
  assign ge    = rem_s >= den;
  assign room  = ACC_MAX - (job_q.sum[ACC_W-1] ? '0 : job_q.sum);

  always_comb begin
    res_val = job_q.sum;
    res_ovf = job_q.sat;
    if (job_q.mode == OP_SPILL) begin
      if (job_q.rnorm == '0 || big_q || quo_q > room) begin
        res_val = ACC_MAX;
        res_ovf = 1'b1;
      end else begin
        res_val = job_q.sum + quo_q;
      end
    end
  end

  assign pop_o    = (state_q == ST_IDLE) & job_valid_i;
  assign load_out = (state_q == ST_OUT) & (~valid_q | m_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      if (load_out)        valid_q <= 1'b1;
      else if (m_tready_i) valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (job_valid_i) begin
          if (job_i.mode == OP_SPILL && job_i.rnorm != '0) state_q <= ST_MUL;
          else                                              state_q <= ST_OUT;
        end
        ST_MUL:  state_q <= ST_ACC;
        ST_ACC:  if (step_q == STEP_W'(MUL_STEPS - 1)) state_q <= ST_DIV;
        ST_DIV:  if (step_q == STEP_W'(DIV_STEPS - 1)) state_q <= ST_OUT;
        ST_OUT:  if (load_out) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        job_q <= job_i;
        big_q <= 1'b0;
        quo_q <= '0;
      end
      ST_MUL: begin
        lp_q   <= NUM_W'(spill_weight_i * pmag);
        pm_q   <= pmag;
        num_q  <= '0;
        step_q <= '0;
      end
      ST_ACC: begin
        if (pm_q[0]) num_q <= num_q + lp_q;
        lp_q   <= lp_q << 1;
        pm_q   <= pm_q >> 1;
        step_q <= (step_q == STEP_W'(MUL_STEPS - 1)) ? '0 : step_q + STEP_W'(1);
        rem_q  <= '0;
      end
      ST_DIV: begin
        num_q  <= num_q << 1;
        rem_q  <= ge ? rem_s - den : rem_s;
        big_q  <= big_q | quo_q[ACC_W-1];
        quo_q  <= {quo_q[ACC_W-2:0], ge};
        step_q <= step_q + STEP_W'(1);
      end
      ST_OUT: if (load_out) begin
        dist_q <= res_val;
        ovf_q  <= res_ovf;
      end
      default: ;
    endcase
  end

  assign m_tvalid_o = valid_q;
  assign distance_o = dist_q;
  assign overflow_o = ovf_q;

endmodule
`default_nettype wire

// File: design/vector_distance_unit.sv
// Top level of the vector distance unit: front end, job queue, back end, weight register.
// Path: a vector's result passes the product register, the job queue, the back end's job
//   register and the output register; the spill-penalized mode adds a setup step, a 48-step
//   multiply and a 112-step divide in the back end, which handles one vector at a time.
// Throughput: one element per cycle into the front end while it is ready; the back end
//   takes a new job only when idle, and once the four-entry job queue fills the input
//   stalls until the back end frees a slot.
// Reset (rst_ni low, asynchronous): accumulators, queue and output valid clear, spill_weight = 1.0.
`default_nettype none
module vector_distance_unit #(
  parameter int ELEM_WIDTH = 16,
  parameter int MAX_DIM    = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // a_elem, b_elem, residual_elem, residual_norm, zero pad
  input  wire logic [((3*ELEM_WIDTH+48+7)/8)*8-1:0] s_axis_tdata,
  // op
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // distance
  output logic [47:0]      m_axis_tdata,
  // overflow
  output logic             m_axis_tuser
);
  import vdu_pkg::*;

  localparam int EW = ELEM_WIDTH;

  logic [LAM_W-1:0]  spill_weight_q;
  logic              push, pop, job_valid;
  job_t              job_in, job_out;
  logic [Q_CW-1:0]   q_count;

  // Lambda register, unsigned Q8.8; reset to 1.0.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spill_weight_q <= LAM_W'(256);
    end else if (cfg_we_i) begin
      spill_weight_q <= cfg_wdata_i;
    end
  end

  // Front end: products and running sums, one transfer per cycle while the queue has room.
  vdu_front #(.EW(EW), .MAX_DIM(MAX_DIM)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .op_i      (s_axis_tuser),
    .a_i       (s_axis_tdata[EW-1:0]),
    .b_i       (s_axis_tdata[2*EW-1:EW]),
    .r_i       (s_axis_tdata[3*EW-1:2*EW]),
    .rnorm_i   (s_axis_tdata[3*EW+ACC_W-1:3*EW]),
    .last_i    (s_axis_tlast),
    .q_count_i (q_count),
    .push_o    (push),
    .job_o     (job_in)
  );

  // Finished vectors wait here for the back end.
  vdu_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .valid_o (job_valid),
    .data_o  (job_out),
    .count_o (q_count)
  );

  // Back end: penalty, saturation and the output register.
  vdu_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_i          (job_out),
    .pop_o          (pop),
    .spill_weight_i (spill_weight_q),
    .m_tvalid_o     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .distance_o     (m_axis_tdata),
    .overflow_o     (m_axis_tuser)
  );

endmodule
`default_nettype wire

// File: design/vdu_checker.sv
// Port-level checks for the vector distance unit, bound to the top level.
`default_nettype none
module vdu_checker #(
  parameter int MAX_DIM = 4096
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);
  localparam int NW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  // Count vectors in versus results out; a vector also closes at the length limit.
  logic [15:0]   open_q;
  logic [NW-1:0] elem_q;
  logic          in_fire, close;

  assign in_fire = s_axis_tvalid & s_axis_tready;
  assign close   = s_axis_tlast | (elem_q == NW'(MAX_DIM - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
      elem_q <= '0;
    end else begin
      if (in_fire) elem_q <= close ? '0 : elem_q + NW'(1);
      open_q <= open_q + 16'(in_fire & close)
                       - 16'(m_axis_tvalid & m_axis_tready);
    end
  end

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && open_q == '0 |-> 1'b0)
    else $error("result without a closed vector");

endmodule

bind vector_distance_unit vdu_checker #(.MAX_DIM(MAX_DIM)) u_vdu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
